@@ design/assert_macros.svh @@
// Assertion macros used by the deque unit controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ design/bdq_pkg.sv @@
// Types and constants of the bounded deque unit
`timescale 1ns / 1ps
package bdq_pkg;
   localparam int unsigned OP_W = 4;
   localparam int unsigned VAL_W = 32;
   localparam logic [OP_W-1:0] OP_ADD_F = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD_B = 4'd1;
   localparam logic [OP_W-1:0] OP_EMIT_ALL = 4'd2;
   localparam logic [OP_W-1:0] OP_DEL_F = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_B = 4'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 4'd5;
   localparam logic [OP_W-1:0] OP_DEL_V = 4'd6;
   localparam logic [OP_W-1:0] OP_EMIT_F = 4'd7;
   localparam logic [OP_W-1:0] OP_EMIT_L = 4'd8;
   localparam logic [1:0] ST_VALUE = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic signed [VAL_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] item_value;
      logic [1:0] status;
      logic last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, set up walk
      logic rd;         // issue store read at walk index
      logic scan_step;  // delete-by-value: consume read word
      logic emit;       // present read word as a value result
      logic stat;       // present a status result
      logic [1:0] stat_code;
      logic commit_simple; // apply add / delete / clear
      logic commit_scan;   // apply new count after value delete
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic full;
      logic empty;
      logic walk_zero;   // nothing to walk
      logic walk_done;   // read index reached walk length
      logic removed;     // value delete found a match
   } sts_type;
endpackage

@@ design/bdq_datapath.sv @@
// Datapath of the deque unit: ring store, pointers and walk counters
`timescale 1ns / 1ps
module bdq_datapath #(
   parameter int unsigned DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  bdq_pkg::req_type req,
   input  bdq_pkg::cmd_type cmd,
   output bdq_pkg::sts_type sts,
   output bdq_pkg::rsp_type rsp_data
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [bdq_pkg::VAL_W-1:0] mem [DEPTH];
   logic [bdq_pkg::VAL_W-1:0] rdata_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] front_ff, front_in;
   logic [bdq_pkg::OP_W-1:0] op_ff;
   logic [bdq_pkg::VAL_W-1:0] val_ff;
   logic [CW-1:0] base_ff, len_ff, idx_ff, kept_ff;
   logic [CW-1:0] clamp_n;
   logic [CW:0] slot_sum;
   logic [AW-1:0] rd_slot, wr_slot, kept_slot;
   logic wr_en;
   logic [bdq_pkg::VAL_W-1:0] wr_data;

   // map a logical position onto a ring slot (sum stays below 2*DEPTH)
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [CW-1:0] i);
      logic [CW:0] s;
      s = (CW+1)'(f) + (CW+1)'(i);
      if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
      return s[AW-1:0];
   endfunction

   always_comb begin
      if (req.operand_value[bdq_pkg::VAL_W-1]) clamp_n = '0;
      else if (req.operand_value < $signed({1'b0, {(bdq_pkg::VAL_W-CW-1){1'b0}}, count_ff}))
         clamp_n = req.operand_value[CW-1:0];
      else clamp_n = count_ff;
   end

   assign slot_sum = (CW+1)'(base_ff) + (CW+1)'(idx_ff);
   assign rd_slot = slot_of(front_ff, slot_sum[CW-1:0]);
   assign kept_slot = slot_of(front_ff, kept_ff);

   always_comb begin
      count_in = count_ff;
      front_in = front_ff;
      wr_en = 1'b0;
      wr_slot = kept_slot;
      wr_data = rdata_ff;
      if (cmd.commit_simple) begin
         unique case (op_ff)
            bdq_pkg::OP_ADD_F: begin
               front_in = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
               wr_en = 1'b1;
               wr_slot = front_in;
               wr_data = val_ff;
               count_in = count_ff + CW'(1);
            end
            bdq_pkg::OP_ADD_B: begin
               wr_en = 1'b1;
               wr_slot = slot_of(front_ff, count_ff);
               wr_data = val_ff;
               count_in = count_ff + CW'(1);
            end
            bdq_pkg::OP_DEL_F: begin
               front_in = slot_of(front_ff, CW'(1));
               count_in = count_ff - CW'(1);
            end
            bdq_pkg::OP_DEL_B: count_in = count_ff - CW'(1);
            bdq_pkg::OP_CLEAR: begin
               count_in = '0;
               front_in = '0;
            end
            default: ;
         endcase
      end
      if (cmd.scan_step && rdata_ff != val_ff) wr_en = 1'b1;
      if (cmd.commit_scan) count_in = kept_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_slot] <= wr_data;
      if (cmd.rd) rdata_ff <= mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         front_ff <= '0;
      end else begin
         count_ff <= count_in;
         front_ff <= front_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req.opcode;
         val_ff <= req.operand_value;
         idx_ff <= '0;
         kept_ff <= '0;
         base_ff <= '0;
         priority case (req.opcode)
            bdq_pkg::OP_EMIT_F: len_ff <= clamp_n;
            bdq_pkg::OP_EMIT_L: begin
               len_ff <= clamp_n;
               base_ff <= count_ff - clamp_n;
            end
            default: len_ff <= count_ff;
         endcase
      end else begin
         if (cmd.rd) idx_ff <= idx_ff + CW'(1);
         if (cmd.scan_step && rdata_ff != val_ff) kept_ff <= kept_ff + CW'(1);
      end
   end

   always_comb begin
      sts.opcode = op_ff;
      sts.full = (count_ff >= DEPTH_C);
      sts.empty = (count_ff == '0);
      sts.walk_zero = (len_ff == '0);
      sts.walk_done = (idx_ff >= len_ff);
      sts.removed = (kept_ff != count_ff);
   end

   always_comb begin
      rsp_data.item_value = cmd.emit ? rdata_ff : '0;
      rsp_data.status = cmd.emit ? bdq_pkg::ST_VALUE : cmd.stat_code;
      rsp_data.last = cmd.stat | (cmd.emit & sts.walk_done);
   end
endmodule

@@ design/bdq_ctrl.sv @@
// Controller of the deque unit: sequences one request at a time
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  bdq_pkg::sts_type sts,
   output bdq_pkg::cmd_type cmd,
   output logic rsp_valid
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DEC  = 5'b00010,
      S_RD   = 5'b00100,
      S_EMIT = 5'b01000,
      S_SCAN = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic is_emit;

   assign is_emit = (sts.opcode == bdq_pkg::OP_EMIT_ALL) || (sts.opcode == bdq_pkg::OP_EMIT_F)
                    || (sts.opcode == bdq_pkg::OP_EMIT_L);
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.stat_code = bdq_pkg::ST_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start) state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_IDLE;
            if (is_emit) begin
               if (sts.walk_zero) cmd.stat = 1'b1;
               else begin
                  cmd.rd = 1'b1;
                  state_in = S_RD;
               end
            end else if (sts.opcode == bdq_pkg::OP_DEL_V) begin
               if (sts.empty) cmd.stat = 1'b1;
               else begin
                  cmd.rd = 1'b1;
                  state_in = S_SCAN;
               end
            end else begin
               cmd.stat = 1'b1;
               priority case (sts.opcode)
                  bdq_pkg::OP_ADD_F, bdq_pkg::OP_ADD_B: begin
                     cmd.stat_code = sts.full ? bdq_pkg::ST_FULL : bdq_pkg::ST_DONE;
                     cmd.commit_simple = !sts.full;
                  end
                  bdq_pkg::OP_DEL_F, bdq_pkg::OP_DEL_B: begin
                     cmd.stat_code = sts.empty ? bdq_pkg::ST_NONE : bdq_pkg::ST_DONE;
                     cmd.commit_simple = !sts.empty;
                  end
                  bdq_pkg::OP_CLEAR: begin
                     cmd.stat_code = bdq_pkg::ST_DONE;
                     cmd.commit_simple = 1'b1;
                  end
                  default: cmd.stat_code = bdq_pkg::ST_NONE;
               endcase
            end
         end
         S_RD: begin
            cmd.emit = 1'b1;
            if (sts.walk_done) state_in = S_IDLE;
            else cmd.rd = 1'b1;
         end
         S_EMIT: begin
            // kept count is final here: take it as the new count
            cmd.commit_scan = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.walk_done) begin
               cmd.stat = 1'b1;
               state_in = S_EMIT;
            end else cmd.rd = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // value-delete status decided in the cycle after the last scan step
   logic scan_fin_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_fin_ff <= (state_ff == S_SCAN) && sts.walk_done;
      end
   end

   // the scan's last step is held back; the status goes out in S_EMIT
   always_comb begin
      rsp_valid = cmd.emit || (cmd.stat && state_ff != S_SCAN) || (state_ff == S_EMIT);
   end

   `ASSERT_IMP(a_start_only_idle, clock, reset, cmd.load, state_ff == S_IDLE)
   `ASSERT_NEXT(a_scan_to_emit, clock, reset, state_ff == S_SCAN && sts.walk_done, state_ff == S_EMIT)
   `ASSERT_IMP(a_emit_after_scan, clock, reset, state_ff == S_EMIT, scan_fin_ff)
endmodule

@@ design/bounded_deque_with_value_delete_unit.sv @@
// Top level of the bounded deque unit with delete by value
`timescale 1ns / 1ps
// Channel  Ports                          Direction  Handshake
// request  start, busy, req_word          in         start && !busy
// result   rsp_valid, rsp_word            out        rsp_valid, one cycle, no stall
//
// Add, delete at either end and clear go through two steps: capture, then decide.
// Emit of N entries reads the store once per entry, one store read per cycle on the single
// read port. Delete by value walks every entry, one per cycle, then commits the kept count.
// Synchronous reset empties the deque at once; the store itself is not cleared.
// The receiver cannot stall: each result word stands for exactly one cycle.
module bounded_deque_with_value_delete_unit #(
   parameter int unsigned DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  bdq_pkg::req_type req_word,
   output logic rsp_valid,
   output bdq_pkg::rsp_type rsp_word
);
   bdq_pkg::cmd_type cmd;
   bdq_pkg::sts_type sts;
   bdq_pkg::rsp_type dp_rsp;
   bdq_pkg::rsp_type scan_rsp;

   // controller: one request at a time
   bdq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd), .rsp_valid(rsp_valid)
   );

   // datapath: ring store, count, front pointer and walk counters
   bdq_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock(clock), .reset(reset), .req(req_word),
      .cmd(cmd), .sts(sts), .rsp_data(dp_rsp)
   );

   // value delete: status word telling whether any entry was removed, once the walk is over
   always_comb begin
      scan_rsp.item_value = '0;
      scan_rsp.status = sts.removed ? bdq_pkg::ST_DONE : bdq_pkg::ST_NONE;
      scan_rsp.last = 1'b1;
   end

   // pick the scan status word in the cycle after the walk, else the datapath word
   always_comb begin
      if (busy && !cmd.emit && !cmd.stat && !cmd.rd && !cmd.scan_step) rsp_word = scan_rsp;
      else rsp_word = dp_rsp;
   end
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the bounded deque unit with delete by value
`timescale 1ns / 1ps
module tb_top;
   import bdq_pkg::*;

   localparam int unsigned DEPTH = 64;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_word;
   logic rsp_valid;
   rsp_type rsp_word;

   bounded_deque_with_value_delete_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   // predicted deque contents, held as a plain queue front to back
   logic signed [VAL_W-1:0] deque_mirror[$];
   rsp_type expected_words[$];
   req_type pending_words[$];
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   bit stimulus_done = 0;
   bit quiet_phase = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void push_status(logic [1:0] code);
      rsp_type w;
      w.item_value = '0;
      w.status = code;
      w.last = 1'b1;
      expected_words.push_back(w);
   endfunction

   // push value words for entries [first, first+n), or a none status if n is 0
   function automatic void push_values(int first, int n);
      rsp_type w;
      if (n == 0) begin
         push_status(ST_NONE);
         return;
      end
      for (int k = 0; k < n; k++) begin
         w.item_value = deque_mirror[first + k];
         w.status = ST_VALUE;
         w.last = (k == n - 1);
         expected_words.push_back(w);
      end
   endfunction

   // advance the mirror by one request word and queue its answers
   function automatic void predict_deque(req_type rq);
      int n;
      int before_count;
      before_count = deque_mirror.size();
      n = (rq.operand_value < 0) ? 0 :
          ((rq.operand_value > before_count) ? before_count : int'(rq.operand_value));
      case (rq.opcode)
         OP_ADD_F, OP_ADD_B: begin
            if (before_count >= DEPTH) push_status(ST_FULL);
            else begin
               if (rq.opcode == OP_ADD_F) deque_mirror.push_front(rq.operand_value);
               else deque_mirror.push_back(rq.operand_value);
               push_status(ST_DONE);
            end
         end
         OP_EMIT_ALL: push_values(0, before_count);
         OP_DEL_F, OP_DEL_B: begin
            if (before_count == 0) push_status(ST_NONE);
            else begin
               if (rq.opcode == OP_DEL_F) void'(deque_mirror.pop_front());
               else void'(deque_mirror.pop_back());
               push_status(ST_DONE);
            end
         end
         OP_CLEAR: begin
            deque_mirror.delete();
            push_status(ST_DONE);
         end
         OP_DEL_V: begin
            for (int k = deque_mirror.size() - 1; k >= 0; k--)
               if (deque_mirror[k] == rq.operand_value) deque_mirror.delete(k);
            push_status(deque_mirror.size() == before_count ? ST_NONE : ST_DONE);
         end
         OP_EMIT_F: push_values(0, n);
         OP_EMIT_L: push_values(before_count - n, n);
         default: push_status(ST_NONE);
      endcase
   endfunction

   function automatic req_type make_word(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v);
      req_type r;
      r.opcode = op;
      r.operand_value = v;
      return r;
   endfunction

   // values mostly from a small pool so that delete by value finds matches
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'sh8000_0000 + $urandom_range(0, 3);
         2: return 32'sh7fff_fffc + $urandom_range(0, 3);
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   function automatic req_type random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return make_word(OP_ADD_B, pick_value());
      if (r < 50) return make_word(OP_ADD_F, pick_value());
      if (r < 58) return make_word(OP_DEL_F, pick_value());
      if (r < 66) return make_word(OP_DEL_B, pick_value());
      if (r < 74) return make_word(OP_DEL_V, pick_value());
      if (r < 80) return make_word(OP_EMIT_ALL, pick_value());
      if (r < 87) return make_word(OP_EMIT_F, $urandom_range(0, 1) ? $urandom_range(0, 70)
                                             : $urandom());
      if (r < 94) return make_word(OP_EMIT_L, $urandom_range(0, 1) ? $urandom_range(0, 70)
                                             : $urandom());
      if (r < 96) return make_word(OP_CLEAR, pick_value());
      return make_word(4'($urandom_range(9, 15)), $urandom());
   endfunction

   // fill the pending queue: directed words first, then random traffic
   initial begin
      pending_words.push_back(make_word(OP_DEL_F, 0));
      pending_words.push_back(make_word(OP_DEL_B, 0));
      pending_words.push_back(make_word(OP_EMIT_ALL, 0));
      pending_words.push_back(make_word(OP_DEL_V, 5));
      pending_words.push_back(make_word(OP_ADD_B, 32'sh7fff_ffff));
      pending_words.push_back(make_word(OP_DEL_B, 0));
      pending_words.push_back(make_word(OP_ADD_F, 32'sh8000_0000));
      pending_words.push_back(make_word(OP_DEL_F, 0));
      pending_words.push_back(make_word(OP_ADD_B, -1));
      pending_words.push_back(make_word(OP_ADD_F, 0));
      pending_words.push_back(make_word(OP_ADD_B, -1));
      pending_words.push_back(make_word(OP_EMIT_F, -1));
      pending_words.push_back(make_word(OP_EMIT_F, 32'sh7fff_ffff));
      pending_words.push_back(make_word(OP_EMIT_L, 1));
      pending_words.push_back(make_word(OP_EMIT_L, 0));
      pending_words.push_back(make_word(OP_EMIT_L, 99));
      pending_words.push_back(make_word(OP_DEL_V, -1));
      pending_words.push_back(make_word(OP_DEL_V, 7));
      pending_words.push_back(make_word(4'hF, 32'shffff_ffff));
      pending_words.push_back(make_word(4'h9, 0));
      // fill to capacity, overflow at both ends, then walk the full store
      for (int k = 0; k < DEPTH; k++) pending_words.push_back(make_word(OP_ADD_B, k % 5));
      pending_words.push_back(make_word(OP_ADD_F, 1));
      pending_words.push_back(make_word(OP_ADD_B, 1));
      pending_words.push_back(make_word(OP_EMIT_ALL, 0));
      pending_words.push_back(make_word(OP_DEL_V, 3));
      pending_words.push_back(make_word(OP_CLEAR, 0));
      for (int k = 0; k < 410; k++) pending_words.push_back(random_word());
   end

   int unsigned gap_left = 0;

   // driver: offer the next word, holding start across back-to-back words
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_word <= '0;
      end else begin
         if (start && !busy) begin
            predict_deque(req_word);
         end
         if (start && busy) begin
            // hold the offered word until taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 5);
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_word <= pending_words.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            if (!(start && !busy) && !start) stimulus_done = 1;
         end
         quiet_phase = (pending_words.size() < 60);
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word %p", rsp_word);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_words.pop_front();
               if (rsp_word.item_value !== e.item_value) begin
                  $error("item_value expected %0d got %0d", e.item_value, rsp_word.item_value);
                  fail_count++;
               end
               if (rsp_word.status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_word.status);
                  fail_count++;
               end
               if (rsp_word.last !== e.last) begin
                  $error("last expected %0d got %0d", e.last, rsp_word.last);
                  fail_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // reset, wait for drain, settle, then report
   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && expected_words.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         // let any stray word show up before the verdict
         repeat (DEPTH + 10) @(posedge clock);
         if (fail_count == 0 && expected_words.size() == 0) begin
            $display("== PASS ==");
         end else begin
            $display("== FAIL ==");
         end
         $finish;
      end
   end
endmodule

@@ filelist.f @@
+incdir+design
design/bdq_pkg.sv
design/bdq_datapath.sv
design/bdq_ctrl.sv
design/bounded_deque_with_value_delete_unit.sv
verif/tb_top.sv
